// ===== rtl/dfs_topological_sort_macros.svh =====
// Assertion macros for the dfs_topological_sort block.
// Define NO_ASSERTIONS to compile them out.
`ifndef DFS_TOPOLOGICAL_SORT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DTS_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
		else $error("assertion failed");
`define DTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DTS_ASSERT(lbl, clk, rstn, expr)
`define DTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/dts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;
	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 256;
	localparam int ID_W = 6;
	localparam int NC_W = 7;
	localparam int NW   = $clog2(MAX_NODES);
	localparam int DW   = $clog2(MAX_NODES + 1);
	localparam int EW   = $clog2(MAX_EDGES);
	localparam int ECW  = $clog2(MAX_EDGES + 1);

	localparam logic [ECW-1:0] NO_EDGE = ECW'(MAX_EDGES);

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_RUN    = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_DIRECTED   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_ADD_LINK,
		ST_ROOT,
		ST_PUSH,
		ST_STEP,
		ST_EDGE,
		ST_POP_LD,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/dts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/dfs_topological_sort.sv =====
`timescale 1ns / 1ps
// Add edge stores one entry per edge, two entries when undirected. Clear empties the graph.
// Run walks each root, pushes nodes, scans edges and finishes nodes, then emits the requests.
// The single sequencer walks one node or edge through the shared RAM ports at a time.
// Asynchronous active-low reset: graph empty, node_count 64, directed 1, no request pending.
`default_nettype none
`include "dfs_topological_sort_macros.svh"
module dfs_topological_sort
	import dts_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	// configuration write port
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [NC_W-1:0] cfg_data,
	// input channel
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      kind,
	input  wire logic [ID_W-1:0] src_node,
	input  wire logic [ID_W-1:0] dst_node,
	// output channel
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [ID_W-1:0]      node_id,
	output logic                 last,
	output logic                 edge_overflow
);
	// Sequencer state
	state_t state_q, state_d;

	// Configuration
	logic [NC_W-1:0] node_count_q;
	logic            directed_q;

	// Graph bookkeeping: head-valid bits stand in for the empty-list marker
	logic [ECW-1:0]       used_q;
	logic                 ovf_q;
	logic [MAX_NODES-1:0] hv_q;

	// Add-edge working registers
	logic [ID_W-1:0] from_q, to_q;
	logic            second_q;
	logic [EW-1:0]   tail_q, e_q;

	// Walk registers; the stack top is cached, the rest lives in the stack RAM
	logic [MAX_NODES-1:0] visited_q;
	logic [NC_W-1:0]      r_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        cur_node_q;
	logic [ECW-1:0]       cur_next_q;
	logic [DW-1:0]        depth_q;
	logic [DW-1:0]        fcount_q;
	logic [NW-1:0]        idx_q;

	// Output register
	logic            out_valid_q;
	logic [ID_W-1:0] node_id_q;
	logic            last_q;
	logic            ovf_out_q;

	// RAM ports
	logic            tgt_we, tgt_re;
	logic [EW-1:0]   tgt_waddr, tgt_raddr;
	logic [NW-1:0]   tgt_wdata, tgt_rdata;
	logic            link_we, link_re;
	logic [EW-1:0]   link_waddr, link_raddr;
	logic [ECW-1:0]  link_wdata, link_rdata;
	logic            node_we, node_re;
	logic [NW-1:0]   node_waddr, node_raddr;
	logic [2*EW-1:0] node_wdata, node_rdata;
	logic            stk_we, stk_re;
	logic [NW-1:0]   stk_waddr, stk_raddr;
	logic [NW+ECW-1:0] stk_wdata, stk_rdata;
	logic            fin_we, fin_re;
	logic [NW-1:0]   fin_waddr, fin_raddr;
	logic [NW-1:0]   fin_wdata, fin_rdata;

	// Derived values
	logic            in_acc;
	logic            out_free;
	logic            add_bad;
	logic            full;
	logic [NC_W-1:0] roots;
	logic [DW-1:0]   dm1, dm2;
	logic [EW-1:0]   head_rd, tail_rd;
	logic [DW-1:0]   fm1;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	// an endpoint beyond the node table drops the entry
	assign add_bad   = ({1'b0, from_q} >= (ID_W+1)'(MAX_NODES))
		|| ({1'b0, to_q} >= (ID_W+1)'(MAX_NODES));
	assign full      = (used_q == ECW'(MAX_EDGES));
	assign roots     = (node_count_q > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : node_count_q;
	assign dm1       = depth_q - DW'(1);
	assign dm2       = depth_q - DW'(2);
	assign fm1       = fcount_q - DW'(1);
	assign head_rd   = node_rdata[2*EW-1:EW];
	assign tail_rd   = node_rdata[EW-1:0];

	assign out_valid     = out_valid_q;
	assign node_id       = node_id_q;
	assign last          = last_q;
	assign edge_overflow = ovf_out_q;

	// Next state and RAM control
	always_comb begin
		state_d    = state_q;
		tgt_we     = 1'b0;
		tgt_re     = 1'b0;
		tgt_waddr  = used_q[EW-1:0];
		tgt_raddr  = cur_next_q[EW-1:0];
		tgt_wdata  = to_q[NW-1:0];
		link_we    = 1'b0;
		link_re    = 1'b0;
		link_waddr = used_q[EW-1:0];
		link_raddr = cur_next_q[EW-1:0];
		link_wdata = NO_EDGE;
		node_we    = 1'b0;
		node_re    = 1'b0;
		node_waddr = from_q[NW-1:0];
		node_raddr = from_q[NW-1:0];
		node_wdata = {(hv_q[from_q[NW-1:0]] ? head_rd : used_q[EW-1:0]), used_q[EW-1:0]};
		stk_we     = 1'b0;
		stk_re     = 1'b0;
		stk_waddr  = dm1[NW-1:0];
		stk_raddr  = dm2[NW-1:0];
		stk_wdata  = {cur_node_q, cur_next_q};
		fin_we     = 1'b0;
		fin_re     = 1'b0;
		fin_waddr  = fcount_q[NW-1:0];
		fin_raddr  = idx_q;
		fin_wdata  = cur_node_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_ADD: state_d = ST_ADD_RD;
						KIND_RUN: state_d = ST_ROOT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: begin
				if (add_bad || full) begin
					state_d = second_q ? ST_ADD_RD : ST_IDLE;
				end else begin
					node_re = 1'b1;
					state_d = ST_ADD_WR;
				end
			end
			ST_ADD_WR: begin
				tgt_we  = 1'b1;
				link_we = 1'b1;
				node_we = 1'b1;
				if (hv_q[from_q[NW-1:0]]) begin
					state_d = ST_ADD_LINK;
				end else begin
					state_d = second_q ? ST_ADD_RD : ST_IDLE;
				end
			end
			ST_ADD_LINK: begin
				// chain the new entry behind the old tail
				link_we    = 1'b1;
				link_waddr = tail_q;
				link_wdata = ECW'(e_q);
				state_d    = second_q ? ST_ADD_RD : ST_IDLE;
			end
			ST_ROOT: begin
				node_raddr = r_q[NW-1:0];
				if (r_q == roots) begin
					state_d = ST_EMIT_RD;
				end else if (!visited_q[r_q[NW-1:0]]) begin
					node_re = 1'b1;
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				// spill the cached top below the new one
				stk_we  = (depth_q != '0);
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (cur_next_q == NO_EDGE) begin
					fin_we = (fcount_q < DW'(MAX_NODES));
					if (depth_q == DW'(1)) begin
						state_d = ST_ROOT;
					end else begin
						stk_re  = 1'b1;
						state_d = ST_POP_LD;
					end
				end else begin
					tgt_re  = 1'b1;
					link_re = 1'b1;
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				node_raddr = tgt_rdata;
				if (!visited_q[tgt_rdata]) begin
					node_re = 1'b1;
					state_d = ST_PUSH;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_POP_LD: state_d = ST_STEP;
			ST_EMIT_RD: begin
				if (fcount_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					fin_re  = 1'b1;
					state_d = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					state_d = (idx_q == '0) ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NC_W'(64);
			directed_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				CFG_DIRECTED:   directed_q   <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			ovf_q       <= 1'b0;
			hv_q        <= '0;
			visited_q   <= '0;
			depth_q     <= '0;
			fcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new request, or drop the one just taken
			if (state_q == ST_EMIT_LD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind == KIND_RUN) begin
						visited_q <= '0;
						depth_q   <= '0;
						fcount_q  <= '0;
					end else if (in_acc && kind == KIND_CLEAR) begin
						hv_q   <= '0;
						used_q <= '0;
						ovf_q  <= 1'b0;
					end
				end
				ST_ADD_RD: begin
					if (add_bad || full) begin
						ovf_q <= 1'b1;
					end
				end
				ST_ADD_WR: begin
					hv_q[from_q[NW-1:0]] <= 1'b1;
					used_q <= used_q + ECW'(1);
				end
				ST_PUSH: begin
					visited_q[n_q] <= 1'b1;
					depth_q        <= depth_q + DW'(1);
				end
				ST_STEP: begin
					if (cur_next_q == NO_EDGE) begin
						if (fcount_q < DW'(MAX_NODES)) begin
							fcount_q <= fcount_q + DW'(1);
						end
						depth_q <= dm1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					from_q   <= src_node;
					to_q     <= dst_node;
					second_q <= !directed_q;
					r_q      <= '0;
				end
			end
			ST_ADD_RD: begin
				if ((add_bad || full) && second_q) begin
					from_q   <= to_q;
					to_q     <= from_q;
					second_q <= 1'b0;
				end
			end
			ST_ADD_WR: begin
				e_q    <= used_q[EW-1:0];
				tail_q <= tail_rd;
				if (!hv_q[from_q[NW-1:0]] && second_q) begin
					from_q   <= to_q;
					to_q     <= from_q;
					second_q <= 1'b0;
				end
			end
			ST_ADD_LINK: begin
				if (second_q) begin
					from_q   <= to_q;
					to_q     <= from_q;
					second_q <= 1'b0;
				end
			end
			ST_ROOT: begin
				if (r_q == roots) begin
					idx_q <= fm1[NW-1:0];
				end else if (visited_q[r_q[NW-1:0]]) begin
					r_q <= r_q + NC_W'(1);
				end else begin
					n_q <= r_q[NW-1:0];
				end
			end
			ST_PUSH: begin
				cur_node_q <= n_q;
				cur_next_q <= hv_q[n_q] ? ECW'(head_rd) : NO_EDGE;
			end
			ST_EDGE: begin
				cur_next_q <= link_rdata;
				n_q        <= tgt_rdata;
			end
			ST_POP_LD: begin
				{cur_node_q, cur_next_q} <= stk_rdata;
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					node_id_q <= ID_W'(fin_rdata);
					last_q    <= (idx_q == '0);
					ovf_out_q <= ovf_q;
					idx_q     <= idx_q - NW'(1);
				end
			end
			default: ;
		endcase
	end

	// Edge store: target and link, one entry per stored edge
	dts_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_tgt_ram (
		.clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
		.re(tgt_re), .raddr(tgt_raddr), .rdata(tgt_rdata)
	);
	dts_ram #(.WIDTH(ECW), .DEPTH(MAX_EDGES)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.re(link_re), .raddr(link_raddr), .rdata(link_rdata)
	);
	// Per-node list head and tail
	dts_ram #(.WIDTH(2*EW), .DEPTH(MAX_NODES)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(node_rdata)
	);
	// Walk stack below the cached top
	dts_ram #(.WIDTH(NW+ECW), .DEPTH(MAX_NODES)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
	);
	// Finish order, read back in reverse
	dts_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fin_ram (
		.clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
		.re(fin_re), .raddr(fin_raddr), .rdata(fin_rdata)
	);

	`DTS_ASSERT(a_depth_bound, clk, arst_n, depth_q <= DW'(MAX_NODES))
	`DTS_ASSERT(a_fcount_bound, clk, arst_n, fcount_q <= DW'(MAX_NODES))
	`DTS_ASSERT_NEXT(a_clear_empties, clk, arst_n, in_acc && kind == KIND_CLEAR, used_q == '0 && !ovf_q && hv_q == '0)
	`DTS_ASSERT_NEXT(a_push_marks, clk, arst_n, state_q == ST_PUSH, visited_q[n_q] && depth_q != '0)
endmodule
`default_nettype wire
